/* sv/char_lcd_nibble_write_sequencer_top_macros.svh */
// assertion helpers for the lcd sequencer checker
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_TOP_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LCDSEQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define LCDSEQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lcdseq_pkg.sv */
package lcdseq_pkg;

  // input operation codes
  localparam logic [1:0] FUNC_CMD    = 2'd0;
  localparam logic [1:0] FUNC_DATA   = 2'd1;
  localparam logic [1:0] FUNC_CURSOR = 2'd2;
  localparam logic [1:0] FUNC_INIT   = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_SET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_OFF     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_MODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_ON      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_ADDRESS  = 3'd5;

  localparam int HOLD_W = 14;

  // fixed power-up bytes and waits
  localparam logic [7:0] WAKE_BYTE0 = 8'h33;
  localparam logic [7:0] WAKE_BYTE1 = 8'h32;
  localparam logic [HOLD_W-1:0] POWER_WAIT_MS = 14'd15000;
  localparam int WAKE_EXTRA_MS  = 100;
  localparam int CLEAR_EXTRA_MS = 2000;
  localparam int ADDR_EXTRA_MS  = 4000;
  localparam logic [2:0] INIT_LAST_IDX = 3'd6;

  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic [7:0] function_set;
    logic [7:0] disp_off;
    logic [7:0] clear;
    logic [7:0] entry_mode;
    logic [7:0] disp_on;
    logic [7:0] set_address;
  } cfg_t;

  // one classified request for the step sequencer
  typedef struct packed {
    logic       init;
    logic       rs;
    logic       addr_wait;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic              rs;
    logic [3:0]        nibble;
    logic              enable;
    logic              backlight;
    logic [HOLD_W-1:0] hold_ms;
    logic              last;
  } step_t;

  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] b;
    case (row)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

endpackage

/* sv/char_lcd_nibble_write_sequencer_top.sv */
// a request's first step word passes through the request queue and the output register
// one step word per cycle from the back sequencer while the receiver pops: four words
// per byte request, thirty for power-up; a 2-word request queue sits in front
// reset: synchronous active-low rst_n empties the queue and output register, clears the
// sequencer, turns the backlight off and loads the command registers with their defaults
module char_lcd_nibble_write_sequencer_top #(
  parameter int PULSE_MS    = 1,
  parameter int BYTE_GAP_MS = 40
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [1:0]                     in_func,
  input  logic [7:0]                     in_data_byte,
  input  logic [1:0]                     in_row,
  input  logic [4:0]                     in_column,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic                           out_rs,
  output logic [3:0]                     out_nibble,
  output logic                           out_enable,
  output logic                           out_backlight,
  output logic [lcdseq_pkg::HOLD_W-1:0]  out_hold_ms,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [lcdseq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  lcdseq_pkg::cfg_t  cfg_r, cfg_nxt;
  lcdseq_pkg::cmd_t  wr_cmd, rd_cmd;
  lcdseq_pkg::step_t step;
  logic              q_wr, q_rd, q_full, q_empty;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        lcdseq_pkg::CFG_FUNCTION_SET: cfg_nxt.function_set = cfg_data;
        lcdseq_pkg::CFG_DISP_OFF:     cfg_nxt.disp_off     = cfg_data;
        lcdseq_pkg::CFG_CLEAR:        cfg_nxt.clear        = cfg_data;
        lcdseq_pkg::CFG_ENTRY_MODE:   cfg_nxt.entry_mode   = cfg_data;
        lcdseq_pkg::CFG_DISP_ON:      cfg_nxt.disp_on      = cfg_data;
        lcdseq_pkg::CFG_SET_ADDRESS:  cfg_nxt.set_address  = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.function_set <= 8'h2A;
      cfg_r.disp_off     <= 8'h08;
      cfg_r.clear        <= 8'h01;
      cfg_r.entry_mode   <= 8'h06;
      cfg_r.disp_on      <= 8'h0C;
      cfg_r.set_address  <= 8'h80;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lcdseq_front u_front (
    .in_push      (in_push),
    .in_full      (in_full),
    .in_func      (in_func),
    .in_data_byte (in_data_byte),
    .in_row       (in_row),
    .in_column    (in_column),
    .set_address  (cfg_r.set_address),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_cmd        (wr_cmd)
  );

  lcdseq_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_wr),
    .wr_cmd (wr_cmd),
    .full   (q_full),
    .rd_en  (q_rd),
    .rd_cmd (rd_cmd),
    .empty  (q_empty)
  );

  lcdseq_back #(
    .PULSE_MS    (PULSE_MS),
    .BYTE_GAP_MS (BYTE_GAP_MS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_cmd     (rd_cmd),
    .q_rd      (q_rd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_step  (step)
  );

  assign out_rs        = step.rs;
  assign out_nibble    = step.nibble;
  assign out_enable    = step.enable;
  assign out_backlight = step.backlight;
  assign out_hold_ms   = step.hold_ms;
  assign out_last      = step.last;

endmodule

/* sv/lcdseq_queue.sv */
module lcdseq_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  lcdseq_pkg::cmd_t   wr_cmd,
  output logic               full,
  input  logic               rd_en,
  output lcdseq_pkg::cmd_t   rd_cmd,
  output logic               empty
);

  localparam int PTR_W = (lcdseq_pkg::Q_DEPTH > 1) ? $clog2(lcdseq_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(lcdseq_pkg::Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(lcdseq_pkg::Q_DEPTH - 1);

  lcdseq_pkg::cmd_t mem [lcdseq_pkg::Q_DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full   = (count_r == CNT_W'(lcdseq_pkg::Q_DEPTH));
  assign empty  = (count_r == '0);
  assign rd_cmd = mem[rd_ptr_r];
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

/* sv/lcdseq_front.sv */
module lcdseq_front (
  input  logic             in_push,
  output logic             in_full,
  input  logic [1:0]       in_func,
  input  logic [7:0]       in_data_byte,
  input  logic [1:0]       in_row,
  input  logic [4:0]       in_column,
  input  logic [7:0]       set_address,
  input  logic             q_full,
  output logic             q_wr,
  output lcdseq_pkg::cmd_t q_cmd
);

  logic [7:0] addr;

  assign in_full = q_full;
  assign q_wr    = in_push && !q_full;

  // ddram address wraps at 8 bits, column is not range checked
  assign addr = lcdseq_pkg::row_base(in_row) + {3'b000, in_column};

  always_comb begin
    q_cmd.init      = 1'b0;
    q_cmd.rs        = 1'b0;
    q_cmd.addr_wait = 1'b0;
    q_cmd.data      = in_data_byte;
    case (in_func)
      lcdseq_pkg::FUNC_CMD: begin
      end
      lcdseq_pkg::FUNC_DATA: begin
        q_cmd.rs = 1'b1;
      end
      lcdseq_pkg::FUNC_CURSOR: begin
        q_cmd.addr_wait = 1'b1;
        q_cmd.data      = addr | set_address;
      end
      default: begin
        q_cmd.init = 1'b1;
        q_cmd.data = '0;
      end
    endcase
  end

endmodule

/* sv/lcdseq_back.sv */
module lcdseq_back #(
  parameter int PULSE_MS    = 1,
  parameter int BYTE_GAP_MS = 40
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lcdseq_pkg::cfg_t   cfg,
  input  logic               q_empty,
  input  lcdseq_pkg::cmd_t   q_cmd,
  output logic               q_rd,
  output logic               out_empty,
  input  logic               out_pop,
  output lcdseq_pkg::step_t  out_step
);

  localparam int HW = lcdseq_pkg::HOLD_W;
  localparam logic [HW-1:0] HOLD_PULSE = HW'(PULSE_MS);
  localparam logic [HW-1:0] HOLD_GAP   = HW'(BYTE_GAP_MS);
  localparam logic [HW-1:0] HOLD_GAP2  = HW'(2 * BYTE_GAP_MS);
  localparam logic [HW-1:0] HOLD_WAKE  = HW'(BYTE_GAP_MS + lcdseq_pkg::WAKE_EXTRA_MS);
  localparam logic [HW-1:0] HOLD_CLEAR = HW'(BYTE_GAP_MS + lcdseq_pkg::CLEAR_EXTRA_MS);
  localparam logic [HW-1:0] HOLD_ADDR  = HW'(BYTE_GAP_MS + lcdseq_pkg::ADDR_EXTRA_MS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BYTE = 2'd1;
  localparam logic [1:0] ST_BL   = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [2:0] init_idx_r, init_idx_nxt;
  logic       in_init_r, in_init_nxt;
  logic [7:0] cur_byte_r, cur_byte_nxt;
  logic       cur_rs_r, cur_rs_nxt;
  logic       addr_wait_r, addr_wait_nxt;
  logic       backlight_r, backlight_nxt;
  logic       out_valid_r, out_valid_nxt;

  lcdseq_pkg::step_t out_step_r, step;

  logic            can_emit, emit;
  logic [7:0]      byte_v, init_byte;
  logic            rs_v;
  logic [HW-1:0]   hold_end, init_hold;

  assign can_emit  = !out_valid_r || out_pop;
  assign emit      = can_emit && ((state_r != ST_IDLE) || !q_empty);
  assign q_rd      = can_emit && (state_r == ST_IDLE) && !q_empty;
  assign out_empty = !out_valid_r;
  assign out_step  = out_step_r;

  always_comb begin
    case (init_idx_r)
      3'd0:    begin init_byte = lcdseq_pkg::WAKE_BYTE0; init_hold = HOLD_WAKE;  end
      3'd1:    begin init_byte = lcdseq_pkg::WAKE_BYTE1; init_hold = HOLD_GAP2;  end
      3'd2:    begin init_byte = cfg.function_set;       init_hold = HOLD_GAP2;  end
      3'd3:    begin init_byte = cfg.disp_off;           init_hold = HOLD_GAP2;  end
      3'd4:    begin init_byte = cfg.clear;              init_hold = HOLD_CLEAR; end
      3'd5:    begin init_byte = cfg.entry_mode;         init_hold = HOLD_GAP2;  end
      default: begin init_byte = cfg.disp_on;            init_hold = HOLD_GAP2;  end
    endcase
  end

  assign byte_v   = in_init_r ? init_byte : cur_byte_r;
  assign rs_v     = in_init_r ? 1'b0 : cur_rs_r;
  assign hold_end = in_init_r ? init_hold : (addr_wait_r ? HOLD_ADDR : HOLD_GAP);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    init_idx_nxt  = init_idx_r;
    in_init_nxt   = in_init_r;
    cur_byte_nxt  = cur_byte_r;
    cur_rs_nxt    = cur_rs_r;
    addr_wait_nxt = addr_wait_r;
    backlight_nxt = backlight_r;

    step.rs        = 1'b0;
    step.nibble    = '0;
    step.enable    = 1'b0;
    step.backlight = backlight_r;
    step.hold_ms   = '0;
    step.last      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_cmd.init) begin
          // power-up opens with a long wait step with rs, nibble and enable low
          step.hold_ms = lcdseq_pkg::POWER_WAIT_MS;
          if (emit) begin
            state_nxt    = ST_BYTE;
            phase_nxt    = 2'd0;
            init_idx_nxt = '0;
            in_init_nxt  = 1'b1;
          end
        end else begin
          // first step of the byte goes out straight from the queue head
          step.rs      = q_cmd.rs;
          step.nibble  = q_cmd.data[7:4];
          step.enable  = 1'b1;
          step.hold_ms = HOLD_PULSE;
          if (emit) begin
            state_nxt     = ST_BYTE;
            phase_nxt     = 2'd1;
            in_init_nxt   = 1'b0;
            cur_byte_nxt  = q_cmd.data;
            cur_rs_nxt    = q_cmd.rs;
            addr_wait_nxt = q_cmd.addr_wait;
          end
        end
      end
      ST_BYTE: begin
        step.rs     = rs_v;
        step.nibble = phase_r[1] ? byte_v[3:0] : byte_v[7:4];
        step.enable = !phase_r[0];
        case (phase_r)
          2'd0, 2'd2: step.hold_ms = HOLD_PULSE;
          2'd1:       step.hold_ms = '0;
          default:    step.hold_ms = hold_end;
        endcase
        step.last = (phase_r == 2'd3) && !in_init_r;
        if (emit) begin
          phase_nxt = phase_r + 2'd1;
          if (phase_r == 2'd3) begin
            if (!in_init_r) begin
              state_nxt = ST_IDLE;
            end else if (init_idx_r == lcdseq_pkg::INIT_LAST_IDX) begin
              state_nxt = ST_BL;
            end else begin
              init_idx_nxt = init_idx_r + 3'd1;
            end
          end
        end
      end
      ST_BL: begin
        // backlight comes on with the closing step itself
        step.backlight = 1'b1;
        step.last      = 1'b1;
        if (emit) begin
          backlight_nxt = 1'b1;
          in_init_nxt   = 1'b0;
          init_idx_nxt  = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      init_idx_r  <= '0;
      in_init_r   <= 1'b0;
      cur_byte_r  <= '0;
      cur_rs_r    <= 1'b0;
      addr_wait_r <= 1'b0;
      backlight_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      init_idx_r  <= init_idx_nxt;
      in_init_r   <= in_init_nxt;
      cur_byte_r  <= cur_byte_nxt;
      cur_rs_r    <= cur_rs_nxt;
      addr_wait_r <= addr_wait_nxt;
      backlight_r <= backlight_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_step_r <= step;
    end
  end

endmodule

/* sv/lcdseq_checker.sv */
`include "char_lcd_nibble_write_sequencer_top_macros.svh"

module lcdseq_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_empty,
  input logic                             out_pop,
  input logic                             out_rs,
  input logic [3:0]                       out_nibble,
  input logic                             out_enable,
  input logic                             out_backlight,
  input logic [lcdseq_pkg::HOLD_W-1:0]    out_hold_ms,
  input logic                             out_last
);

  // a waiting word holds until taken
  `LCDSEQ_ASSERT_NXT(a_out_hold, clk, rst_n, !out_empty && !out_pop,
    !out_empty && $stable(out_hold_ms) && $stable(out_nibble) && $stable(out_last),
    "result word changed while stalled")

  // a strobe-high step never closes a request
  `LCDSEQ_ASSERT_IMP(a_enable_not_last, clk, rst_n, !out_empty && out_enable, !out_last,
    "last flag on an enable-high step")

  // e high is always followed by the same nibble with e low
  `LCDSEQ_ASSERT_NXT(a_enable_fall, clk, rst_n, !out_empty && out_pop && out_enable,
    out_empty || (!out_enable && $stable(out_nibble) && $stable(out_rs)),
    "enable pulse not closed on the same nibble")

  // once the backlight is on it stays on
  `LCDSEQ_ASSERT_NXT(a_backlight_sticky, clk, rst_n, !out_empty && out_pop && out_backlight,
    out_empty || out_backlight, "backlight dropped after power-up")

endmodule

bind char_lcd_nibble_write_sequencer_top lcdseq_checker u_lcdseq_checker (.*);

/* test/lcd_step_checker.sv */
module lcd_step_checker #(
  parameter int PULSE_MS    = 1,
  parameter int BYTE_GAP_MS = 40
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic                          in_full,
  input  logic [1:0]                    in_func,
  input  logic [7:0]                    in_data_byte,
  input  logic [1:0]                    in_row,
  input  logic [4:0]                    in_column,
  input  logic                          out_empty,
  input  logic                          out_pop,
  input  logic                          out_rs,
  input  logic [3:0]                    out_nibble,
  input  logic                          out_enable,
  input  logic                          out_backlight,
  input  logic [lcdseq_pkg::HOLD_W-1:0] out_hold_ms,
  input  logic                          out_last,
  input  logic                          cfg_we,
  input  logic [lcdseq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output int                            n_errors,
  output int                            n_pending,
  output int                            n_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] LINE_START [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

  lcdseq_pkg::cfg_t  lcd_regs;
  logic              backlight_lvl;
  lcdseq_pkg::step_t steps_due [$];

  task automatic flag(input string msg);
    n_errors++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want)
      flag($sformatf("word %0d field %s got %0d want %0d", n_checked, name, got, want));
  endtask

  function automatic void queue_step(input logic rs, input logic [3:0] nib, input logic en,
                                     input int hold, input logic last);
    lcdseq_pkg::step_t s;
    s.rs        = rs;
    s.nibble    = nib;
    s.enable    = en;
    s.backlight = backlight_lvl;
    s.hold_ms   = lcdseq_pkg::HOLD_W'(hold);
    s.last      = last;
    steps_due.push_back(s);
  endfunction

  // high nibble strobed first, then low nibble; the gap rides on the final step
  function automatic void queue_byte(input logic [7:0] b, input logic rs, input int extra,
                                     input logic last);
    queue_step(rs, b[7:4], 1'b1, PULSE_MS, 1'b0);
    queue_step(rs, b[7:4], 1'b0, 0, 1'b0);
    queue_step(rs, b[3:0], 1'b1, PULSE_MS, 1'b0);
    queue_step(rs, b[3:0], 1'b0, BYTE_GAP_MS + extra, last);
  endfunction

  function automatic void predict_request(input logic [1:0] f, input logic [7:0] db,
                                          input logic [1:0] r, input logic [4:0] c);
    logic [7:0] addr;
    logic [7:0] init_bytes [7];
    int         init_extra [7];
    case (f)
      lcdseq_pkg::FUNC_CMD:  queue_byte(db, 1'b0, 0, 1'b1);
      lcdseq_pkg::FUNC_DATA: queue_byte(db, 1'b1, 0, 1'b1);
      lcdseq_pkg::FUNC_CURSOR: begin
        // address wraps at 8 bits, column is not checked against the line
        addr = LINE_START[r] + {3'b000, c};
        queue_byte(addr | lcd_regs.set_address, 1'b0, lcdseq_pkg::ADDR_EXTRA_MS, 1'b1);
      end
      default: begin
        init_bytes = '{lcdseq_pkg::WAKE_BYTE0, lcdseq_pkg::WAKE_BYTE1, lcd_regs.function_set,
                       lcd_regs.disp_off, lcd_regs.clear, lcd_regs.entry_mode,
                       lcd_regs.disp_on};
        init_extra = '{lcdseq_pkg::WAKE_EXTRA_MS, BYTE_GAP_MS, BYTE_GAP_MS, BYTE_GAP_MS,
                       lcdseq_pkg::CLEAR_EXTRA_MS, BYTE_GAP_MS, BYTE_GAP_MS};
        queue_step(1'b0, 4'h0, 1'b0, int'(lcdseq_pkg::POWER_WAIT_MS), 1'b0);
        for (int i = 0; i < 7; i++) queue_byte(init_bytes[i], 1'b0, init_extra[i], 1'b0);
        // backlight only comes on with the closing step
        backlight_lvl = 1'b1;
        queue_step(1'b0, 4'h0, 1'b0, 0, 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    lcdseq_pkg::step_t want;
    if (!rst_n) begin
      lcd_regs = '{function_set: 8'h2A, disp_off: 8'h08, clear: 8'h01,
                   entry_mode: 8'h06, disp_on: 8'h0C, set_address: 8'h80};
      backlight_lvl = 1'b0;
      steps_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lcdseq_pkg::CFG_FUNCTION_SET: lcd_regs.function_set = cfg_data;
          lcdseq_pkg::CFG_DISP_OFF:     lcd_regs.disp_off     = cfg_data;
          lcdseq_pkg::CFG_CLEAR:        lcd_regs.clear        = cfg_data;
          lcdseq_pkg::CFG_ENTRY_MODE:   lcd_regs.entry_mode   = cfg_data;
          lcdseq_pkg::CFG_DISP_ON:      lcd_regs.disp_on      = cfg_data;
          lcdseq_pkg::CFG_SET_ADDRESS:  lcd_regs.set_address  = cfg_data;
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        if (steps_due.size() == 0) begin
          flag("step word popped with nothing expected");
        end else begin
          want = steps_due.pop_front();
          compare_field("rs", out_rs, want.rs);
          compare_field("nibble", out_nibble, want.nibble);
          compare_field("enable", out_enable, want.enable);
          compare_field("backlight", out_backlight, want.backlight);
          compare_field("hold_ms", out_hold_ms, want.hold_ms);
          compare_field("last", out_last, want.last);
          n_checked++;
        end
      end
      if (in_push && !in_full) predict_request(in_func, in_data_byte, in_row, in_column);
    end
    n_pending = steps_due.size();
  end

endmodule

/* test/char_lcd_nibble_write_sequencer_top_tb.sv */
module char_lcd_nibble_write_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LCD_PULSE_MS = 1;
  localparam int LCD_GAP_MS   = 40;

  logic                             clk          = 1'b0;
  logic                             rst_n        = 1'b0;
  logic                             in_push      = 1'b0;
  logic [1:0]                       in_func      = lcdseq_pkg::FUNC_CMD;
  logic [7:0]                       in_data_byte = 8'h00;
  logic [1:0]                       in_row       = 2'd0;
  logic [4:0]                       in_column    = 5'd0;
  logic                             out_pop      = 1'b0;
  logic                             cfg_we       = 1'b0;
  logic [lcdseq_pkg::CFG_IDX_W-1:0] cfg_index    = lcdseq_pkg::CFG_FUNCTION_SET;
  logic [7:0]                       cfg_data     = 8'h00;

  logic                          in_full;
  logic                          out_empty;
  logic                          out_rs;
  logic [3:0]                    out_nibble;
  logic                          out_enable;
  logic                          out_backlight;
  logic [lcdseq_pkg::HOLD_W-1:0] out_hold_ms;
  logic                          out_last;

  int n_errors;
  int n_pending;
  int n_checked;
  int n_requests;
  int n_settings;
  int tx_idle_pct;
  int rx_stall_pct;

  char_lcd_nibble_write_sequencer_top #(
    .PULSE_MS(LCD_PULSE_MS),
    .BYTE_GAP_MS(LCD_GAP_MS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_func(in_func),
    .in_data_byte(in_data_byte),
    .in_row(in_row),
    .in_column(in_column),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_rs(out_rs),
    .out_nibble(out_nibble),
    .out_enable(out_enable),
    .out_backlight(out_backlight),
    .out_hold_ms(out_hold_ms),
    .out_last(out_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  lcd_step_checker #(
    .PULSE_MS(LCD_PULSE_MS),
    .BYTE_GAP_MS(LCD_GAP_MS)
  ) step_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_func(in_func),
    .in_data_byte(in_data_byte),
    .in_row(in_row),
    .in_column(in_column),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_rs(out_rs),
    .out_nibble(out_nibble),
    .out_enable(out_enable),
    .out_backlight(out_backlight),
    .out_hold_ms(out_hold_ms),
    .out_last(out_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .n_errors(n_errors),
    .n_pending(n_pending),
    .n_checked(n_checked)
  );

  always #10 clk = ~clk;

  // receiver side: random pop stalls
  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic push_request(input logic [1:0] f, input logic [7:0] db,
                              input logic [1:0] r, input logic [4:0] c);
    int gap;
    gap = 0;
    // each sender cycle idles with the given chance
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_func      <= f;
    in_data_byte <= db;
    in_row       <= r;
    in_column    <= c;
    @(posedge clk);
    while (in_full) @(posedge clk);
    n_requests++;
  endtask

  task automatic random_request();
    int pick;
    logic [1:0] f;
    pick = $urandom_range(9);
    if (pick == 0)      f = lcdseq_pkg::FUNC_INIT;
    else if (pick <= 3) f = lcdseq_pkg::FUNC_CMD;
    else if (pick <= 6) f = lcdseq_pkg::FUNC_DATA;
    else                f = lcdseq_pkg::FUNC_CURSOR;
    push_request(f, 8'($urandom), 2'($urandom), 5'($urandom));
  endtask

  // let every expected word drain, then hold the inputs quiet before the next phase
  task automatic finish_phase();
    in_push <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lcdseq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input lcdseq_pkg::cfg_t s);
    write_reg(lcdseq_pkg::CFG_FUNCTION_SET, s.function_set);
    write_reg(lcdseq_pkg::CFG_DISP_OFF, s.disp_off);
    write_reg(lcdseq_pkg::CFG_CLEAR, s.clear);
    write_reg(lcdseq_pkg::CFG_ENTRY_MODE, s.entry_mode);
    write_reg(lcdseq_pkg::CFG_DISP_ON, s.disp_on);
    write_reg(lcdseq_pkg::CFG_SET_ADDRESS, s.set_address);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin
    lcdseq_pkg::cfg_t settings;
    tx_idle_pct  = 12;
    rx_stall_pct = 69;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: byte extremes, every line, wide columns, repeated power-up
    push_request(lcdseq_pkg::FUNC_CMD, 8'h00, 2'd0, 5'd0);
    push_request(lcdseq_pkg::FUNC_CMD, 8'hFF, 2'd3, 5'd31);
    push_request(lcdseq_pkg::FUNC_CMD, 8'hA5, 2'd1, 5'd19);
    push_request(lcdseq_pkg::FUNC_DATA, 8'h00, 2'd2, 5'd7);
    push_request(lcdseq_pkg::FUNC_DATA, 8'hFF, 2'd0, 5'd0);
    push_request(lcdseq_pkg::FUNC_DATA, 8'h5A, 2'd3, 5'd31);
    push_request(lcdseq_pkg::FUNC_CURSOR, 8'hFF, 2'd0, 5'd0);
    push_request(lcdseq_pkg::FUNC_CURSOR, 8'h00, 2'd1, 5'd19);
    push_request(lcdseq_pkg::FUNC_CURSOR, 8'hFF, 2'd2, 5'd31);
    push_request(lcdseq_pkg::FUNC_CURSOR, 8'h3C, 2'd3, 5'd31);
    push_request(lcdseq_pkg::FUNC_CURSOR, 8'h00, 2'd3, 5'd0);
    push_request(lcdseq_pkg::FUNC_INIT, 8'hFF, 2'd3, 5'd31);
    push_request(lcdseq_pkg::FUNC_DATA, 8'h41, 2'd0, 5'd0);
    push_request(lcdseq_pkg::FUNC_INIT, 8'h00, 2'd0, 5'd0);
    push_request(lcdseq_pkg::FUNC_CMD, 8'h0F, 2'd2, 5'd12);
    push_request(lcdseq_pkg::FUNC_CURSOR, 8'h80, 2'd1, 5'd0);
    finish_phase();

    for (int p = 1; p <= 5; p++) begin
      case (p)
        1: settings = '0;
        2: settings = lcdseq_pkg::cfg_t'({$urandom(), 16'($urandom())});
        3: settings = '1;
        4: settings = lcdseq_pkg::cfg_t'({$urandom(), 16'($urandom())});
        default: settings = '{function_set: 8'h2A, disp_off: 8'h08, clear: 8'h01,
                              entry_mode: 8'h06, disp_on: 8'h0C, set_address: 8'h80};
      endcase
      if (p == 3) begin
        tx_idle_pct  = 69;
        rx_stall_pct = 12;
      end else if (p == 5) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      load_settings(settings);
      for (int i = 0; i < 62; i++) random_request();
      finish_phase();
    end

    $display("covered %0d requests under %0d register loads plus reset defaults", n_requests,
             n_settings);
    $display("checked %0d step words across sender and receiver stall mixes", n_checked);
    if (n_errors == 0) begin
      $display("char_lcd_nibble_write_sequencer_top_tb passed");
    end else begin
      $display("char_lcd_nibble_write_sequencer_top_tb failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d step words outstanding", n_pending);
    $display("char_lcd_nibble_write_sequencer_top_tb failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/lcdseq_pkg.sv
sv/lcdseq_queue.sv
sv/lcdseq_front.sv
sv/lcdseq_back.sv
sv/char_lcd_nibble_write_sequencer_top.sv
sv/lcdseq_checker.sv
test/lcd_step_checker.sv
test/char_lcd_nibble_write_sequencer_top_tb.sv
